// ===== rtl/scalar_to_rgb_color_palette_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scalar to RGB colour palette
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCALAR_TO_RGB_COLOR_PALETTE_DEFINES_SVH
`define SCALAR_TO_RGB_COLOR_PALETTE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define S2RGB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: palette check failed");

// The consequent must hold in the cycle after the antecedent.
`define S2RGB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: palette check failed");

`else

`define S2RGB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define S2RGB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/s2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// Scalar to RGB colour palette package
// Fixed coefficients of the spectral bumps, register map and the cosine
// helper used to build the lookup tables at elaboration.
// ----------------------------------------------------------------------------
package s2rgb_pkg;

  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned NUM_BUMPS  = 6;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register map, indexed by paddr[2]
  localparam logic REG_PALETTE_MODE = 1'b0;

  // Palette mode codes
  localparam logic MODE_SPECTRAL = 1'b0;
  localparam logic MODE_COSINE   = 1'b1;

  localparam logic [63:0] ONE_30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Eight-decimal coefficient to Q.30, rounded to nearest.
  function automatic logic [63:0] q30(input logic [63:0] n);
    return (n * 64'd1073741824 + 64'd50000000) / 64'd100000000;
  endfunction

  // Bump b = 2*channel + term; channel 0 is red.
  localparam logic [31:0] COEF_C [NUM_BUMPS] = '{
    32'(q30(64'd354585104)), 32'(q30(64'd390307140)),
    32'(q30(64'd293225262)), 32'(q30(64'd321182957)),
    32'(q30(64'd241593945)), 32'(q30(64'd396587128))
  };
  localparam logic [29:0] COEF_X [NUM_BUMPS] = '{
    30'(q30(64'd69549072)), 30'(q30(64'd11748627)),
    30'(q30(64'd49228336)), 30'(q30(64'd86755042)),
    30'(q30(64'd27699880)), 30'(q30(64'd66077860))
  };
  localparam logic [29:0] COEF_Y [NUM_BUMPS] = '{
    30'(q30(64'd2312639)),  30'(q30(64'd84897130)),
    30'(q30(64'd15225084)), 30'(q30(64'd88445281)),
    30'(q30(64'd52607955)), 30'(q30(64'd73949448))
  };

  // Denominators (2n-1)*2n of the Taylor series of cos.
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  // cos(pi/2 * r) for r in [0, 1] in Q.30, result in Q.30 clamped to [0, 1].
  function automatic logic signed [63:0] quarter_cos(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (PI_Q30 * r) >> 31;
    x2   = (x * x) >> 30;
    term = ONE_30;
    sum  = $signed(ONE_30);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum > $signed(ONE_30)) begin
      sum = $signed(ONE_30);
    end
    if (sum < 0) begin
      sum = '0;
    end
    return sum;
  endfunction

endpackage

// ===== rtl/scalar_to_rgb_color_palette.sv =====
// ----------------------------------------------------------------------------
// Scalar to RGB colour palette
// Maps a palette position in [0, 1] to an RGB colour through a pipelined
// square root followed by either spectral bump terms or a cosine lookup.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         intensity, unsigned Q1.FRAC_BITS
//  m_axis    out        red, green, blue, unsigned Q2.FRAC_BITS each
//  apb       in/out     palette_mode register at byte address 0
//
// One beat is taken per cycle while the output is ready or a stage is empty.
// A result passes through an input register, the square root, which
// resolves one root bit per stage over FRAC_BITS + 1 stages, and five
// stages of multipliers and the registered cosine table read.
// Every stage carries a valid bit; a stalled output only holds the stages
// that are full behind it, so bubbles are squeezed out and input is still
// accepted while a result waits as long as some stage is empty. Reset clears
// the valid bits and selects the spectral palette; the cosine tables are
// constant and need no fill.
//
`include "scalar_to_rgb_color_palette_defines.svh"

module scalar_to_rgb_color_palette #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned COS_TABLE_DEPTH = 1024,
  localparam int unsigned IN_TDATA_W     = ((FRAC_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W    = ((3 * (FRAC_BITS + 2) + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // intensity in [FRAC_BITS:0]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
  // red in the lowest FRAC_BITS+2 bits, then green, then blue
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [OUT_TDATA_W-1:0]              m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [s2rgb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [s2rgb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [s2rgb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  import s2rgb_pkg::*;

  localparam int unsigned RADW  = 2 * FRAC_BITS + 1;
  localparam int unsigned TW    = 2 * FRAC_BITS + 2;
  localparam int unsigned CHW   = FRAC_BITS + 2;
  localparam int unsigned AW    = FRAC_BITS + 3;
  localparam int unsigned DW    = $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned PW    = AW + DW;
  localparam int unsigned QW    = PW + 1 - FRAC_BITS;
  localparam int unsigned RW    = $clog2(3 * COS_TABLE_DEPTH);
  localparam int unsigned K     = RW + 1 + ((RW + 1) % 2);
  localparam int unsigned CIW   = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned LAT   = FRAC_BITS + 7;
  localparam int unsigned P0    = FRAC_BITS + 2;
  localparam int unsigned P1    = FRAC_BITS + 3;
  localparam int unsigned P2    = FRAC_BITS + 4;
  localparam int unsigned P3    = FRAC_BITS + 5;
  localparam int unsigned LAST  = FRAC_BITS + 6;

  localparam logic [FRAC_BITS:0] ONE_F     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CHW-1:0]     SPEC_MAX  = {2'b10, {FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0]      THREE_D   = QW'(3 * COS_TABLE_DEPTH);
  localparam logic [QW-1:0]      SIX_D     = QW'(6 * COS_TABLE_DEPTH);
  localparam logic [PW:0]        IDX_ROUND = (PW + 1)'(3) << (FRAC_BITS - 1);
  localparam logic [K-1:0]       RECIP_M   = K'(((64'd1 << K) + 64'd2) / 64'd3);
  localparam logic [31:0]        SPEC_ROUND = 32'd1 << (29 - FRAC_BITS);

  // --------------------------------------------------------------------------
  // Cosine table, 0.5*(1 + cos(2*pi*i/depth)) in Q.FRAC_BITS
  // --------------------------------------------------------------------------
  typedef logic [FRAC_BITS:0] cos_rom_t [COS_TABLE_DEPTH];

  function automatic logic [FRAC_BITS:0] cos_entry(input int unsigned i);
    logic [63:0]        f;
    logic [63:0]        r;
    logic [63:0]        v;
    logic [1:0]         quad;
    logic signed [63:0] c;
    f    = (64'(i) << 32) / 64'(COS_TABLE_DEPTH);
    quad = f[31:30];
    r    = f & (ONE_30 - 64'd1);
    unique case (quad)
      2'd0:    c = quarter_cos(r);
      2'd1:    c = -quarter_cos(ONE_30 - r);
      2'd2:    c = -quarter_cos(r);
      default: c = quarter_cos(ONE_30 - r);
    endcase
    v = 64'($signed(ONE_30) + c) >> 1;
    v = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return v[FRAC_BITS:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      rom[i] = cos_entry(i);
    end
    return rom;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic mode_q;
  logic cfg_wr;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SPECTRAL;
    end else if (cfg_wr && (reg_idx == REG_PALETTE_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = (reg_idx == REG_PALETTE_MODE) ? APB_DATA_W'(mode_q) : '0;

  // --------------------------------------------------------------------------
  // Pipeline control: a stage moves when it is empty or everything ahead
  // of it can move.
  // --------------------------------------------------------------------------
  logic [LAT-1:0] v_q;
  logic [LAT-1:0] v_d;
  logic [LAT-1:0] v_in;
  logic [LAT-1:0] en;
  logic           in_beat;
  logic           out_beat;

  for (genvar g = 0; g < LAT; g++) begin : g_en
    localparam logic [LAT-1:0] LOW_MASK = (LAT'(1) << g) - LAT'(1);
    assign en[g] = m_axis_tready | ~(&(v_q | LOW_MASK));
  end

  assign v_in = {v_q[LAT-2:0], s_axis_tvalid};

  always_comb begin
    for (int i = 0; i < LAT; i++) begin
      v_d[i] = en[i] ? v_in[i] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[LAST];
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign out_beat      = m_axis_tvalid & m_axis_tready;

  // --------------------------------------------------------------------------
  // Input stage and square root, one root bit per stage
  // --------------------------------------------------------------------------
  logic [FRAC_BITS:0] t_in;
  logic [FRAC_BITS:0] t_sat;
  logic [RADW-1:0]    rem_q  [0:FRAC_BITS];
  logic [FRAC_BITS:0] root_q [1:FRAC_BITS+1];

  assign t_in  = s_axis_tdata[FRAC_BITS:0];
  assign t_sat = (t_in > ONE_F) ? ONE_F : t_in;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0] <= {t_sat, {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_sqrt
    localparam int unsigned BI = FRAC_BITS - j;
    logic [FRAC_BITS:0] root_in;
    logic [TW-1:0]      trial;
    logic               take;

    if (j == 0) begin : g_first
      assign root_in = '0;
    end else begin : g_rest
      assign root_in = root_q[j];
    end

    // Adding bit BI to the root raises its square by this much.
    assign trial = (TW'(root_in) << (BI + 1)) + (TW'(1) << (2 * BI));
    assign take  = (TW'(rem_q[j]) >= trial);

    always_ff @(posedge clk_i) begin
      if (en[j+1]) begin
        root_q[j+1] <= take ? (root_in | ((FRAC_BITS + 1)'(1) << BI)) : root_in;
      end
    end

    if (j < FRAC_BITS) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en[j+1]) begin
          rem_q[j+1] <= take ? RADW'(TW'(rem_q[j]) - trial) : rem_q[j];
        end
      end
    end
  end

  logic [FRAC_BITS:0] s_root;
  logic [30:0]        s30;

  assign s_root = root_q[FRAC_BITS+1];
  assign s30    = {s_root, {(30 - FRAC_BITS){1'b0}}};

  // --------------------------------------------------------------------------
  // Spectral palette: clamp(1 - (c*|s-x|)^2 - y, 0, 1) per bump
  // --------------------------------------------------------------------------
  logic [29:0]          ad_q   [NUM_BUMPS];
  logic [61:0]          prod_q [NUM_BUMPS];
  logic [61:0]          sq_q   [NUM_BUMPS];
  logic [NUM_BUMPS-1:0] over_q;
  logic [30:0]          bump_q [NUM_BUMPS];

  for (genvar b = 0; b < NUM_BUMPS; b++) begin : g_bump
    logic [31:0] u;
    logic [32:0] sub;

    assign u   = prod_q[b][61:30];
    assign sub = 33'(sq_q[b][61:30]) + 33'(COEF_Y[b]);

    always_ff @(posedge clk_i) begin
      if (en[P0]) begin
        ad_q[b] <= (s30 >= 31'(COEF_X[b])) ? 30'(s30 - 31'(COEF_X[b]))
                                           : 30'(31'(COEF_X[b]) - s30);
      end
      if (en[P1]) begin
        prod_q[b] <= 62'(COEF_C[b]) * 62'(ad_q[b]);
      end
      if (en[P2]) begin
        // A scaled distance of 2.0 or more always gives an empty bump.
        over_q[b] <= u[31];
        sq_q[b]   <= 62'(u[30:0]) * 62'(u[30:0]);
      end
      if (en[P3]) begin
        bump_q[b] <= (over_q[b] || (sub > 33'(ONE_30[30:0]))) ? '0
                     : 31'(33'(ONE_30[30:0]) - sub);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cosine palette: index = round((s - k/3) * depth) mod depth, worked as
  // floor(q / 3) mod depth with q = floor(depth*(3s + (3-k)) / 2^FRAC_BITS + 3/2).
  // --------------------------------------------------------------------------
  logic [AW-1:0]     a_q    [NUM_CH];
  logic [PW-1:0]     p_q    [NUM_CH];
  logic [RW-1:0]     r_q    [NUM_CH];
  logic [RW+K-1:0]   rp_q   [NUM_CH];
  logic [FRAC_BITS:0] cos_q [NUM_CH];
  logic [CHW-1:0]    spec_q [NUM_CH];
  logic [CHW-1:0]    ch     [NUM_CH];

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    localparam cos_rom_t COS_ROM = build_cos_rom();
    logic [PW:0]   pr;
    logic [QW-1:0] q;
    logic [RW-1:0] r;
    logic [31:0]   sum;

    assign pr = (PW + 1)'(p_q[k]) + IDX_ROUND;
    assign q  = QW'(pr >> FRAC_BITS);

    // q stays below three times three depths, so two compares reduce it.
    always_comb begin
      priority if (q >= SIX_D) begin
        r = RW'(q - SIX_D);
      end else if (q >= THREE_D) begin
        r = RW'(q - THREE_D);
      end else begin
        r = RW'(q);
      end
    end

    assign sum = 32'(bump_q[2*k]) + 32'(bump_q[2*k+1]) + SPEC_ROUND;

    always_ff @(posedge clk_i) begin
      if (en[P0]) begin
        a_q[k] <= (AW'(s_root) << 1) + AW'(s_root) + (AW'(3 - k) << FRAC_BITS);
      end
      if (en[P1]) begin
        p_q[k] <= PW'(a_q[k]) * PW'(COS_TABLE_DEPTH);
      end
      if (en[P2]) begin
        r_q[k] <= r;
      end
      if (en[P3]) begin
        rp_q[k] <= (RW + K)'(r_q[k]) * (RW + K)'(RECIP_M);
      end
      if (en[LAST]) begin
        cos_q[k]  <= COS_ROM[rp_q[k][K +: CIW]];
        spec_q[k] <= sum[31:30-FRAC_BITS];
      end
    end

    assign ch[k] = (mode_q == MODE_COSINE) ? CHW'(cos_q[k]) : spec_q[k];
  end

  assign m_axis_tdata = OUT_TDATA_W'({ch[2], ch[1], ch[0]});

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  function automatic logic [QW-1:0] q_ext(input logic [RW-1:0] val);
    return QW'(val);
  endfunction

  `S2RGB_ASSERT_NXT(a_beat_count, clk_i, rst_ni, 1'b1, $countones(v_q) == $past($countones(v_q)) + int'($past(in_beat)) - int'($past(out_beat)))
  `S2RGB_ASSERT_IMP(a_root_range, clk_i, rst_ni, v_q[FRAC_BITS+1], s_root <= ONE_F)
  `S2RGB_ASSERT_IMP(a_cos_rem_range, clk_i, rst_ni, v_q[P2], (q_ext(r_q[0]) < THREE_D))
  `S2RGB_ASSERT_IMP(a_cos_idx_range, clk_i, rst_ni, v_q[P3], rp_q[0][K +: RW] < RW'(COS_TABLE_DEPTH))
  `S2RGB_ASSERT_IMP(a_spec_range, clk_i, rst_ni, v_q[LAST] && (mode_q == MODE_SPECTRAL), spec_q[0] <= SPEC_MAX)

endmodule

// ===== tb/rgb_palette_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Colour palette result checker
// Watches the intensity stream, the colour stream and the register port. For
// every accepted intensity it computes the expected colour under the current
// palette mode and compares each colour beat with the oldest expectation.
// ----------------------------------------------------------------------------
module rgb_palette_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [55:0]                         m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [s2rgb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [s2rgb_pkg::APB_DATA_W-1:0]    pwdata,
  input  logic [s2rgb_pkg::APB_DATA_W-1:0]    prdata,
  input  logic                                pready,
  output int unsigned                         colours_pending,
  output int unsigned                         mismatches
);
  import s2rgb_pkg::*;

  localparam int unsigned FRAC  = 16;
  localparam int unsigned DEPTH = 1024;
  localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam logic [63:0] UNIT_F   = 64'd1 << FRAC;
  localparam logic [63:0] PI_FIX   = 64'd3373259426;

  // Eight-decimal coefficients; bump 2*channel + term, red first.
  localparam logic [63:0] DEC_C [6] = '{
    64'd354585104, 64'd390307140, 64'd293225262,
    64'd321182957, 64'd241593945, 64'd396587128
  };
  localparam logic [63:0] DEC_X [6] = '{
    64'd69549072, 64'd11748627, 64'd49228336,
    64'd86755042, 64'd27699880, 64'd66077860
  };
  localparam logic [63:0] DEC_Y [6] = '{
    64'd2312639, 64'd84897130, 64'd15225084,
    64'd88445281, 64'd52607955, 64'd73949448
  };

  typedef struct packed {
    logic [17:0] blue;
    logic [17:0] green;
    logic [17:0] red;
  } colour_t;

  colour_t     pending_colours[$];
  colour_t     want;
  colour_t     got;
  logic        mode_copy;
  logic [17:0] cos_lut [DEPTH];

  function automatic logic [63:0] dec_to_q30(input logic [63:0] n);
    return (n * 64'd1073741824 + 64'd50000000) / 64'd100000000;
  endfunction

  // cos(pi/2 * r) for r in [0, 1] in Q.30, by a Taylor series through the x^20 term.
  function automatic logic signed [63:0] cos_quadrant(input logic [63:0] r);
    logic [63:0]        ang;
    logic [63:0]        ang_sq;
    logic [63:0]        term;
    logic signed [63:0] acc;
    ang    = (PI_FIX * r) >> 31;
    ang_sq = (ang * ang) >> 30;
    term   = UNIT_Q30;
    acc    = $signed(UNIT_Q30);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc > $signed(UNIT_Q30)) begin
      acc = $signed(UNIT_Q30);
    end
    if (acc < 0) begin
      acc = 0;
    end
    return acc;
  endfunction

  function automatic logic [63:0] root_q16(input logic [63:0] arg);
    logic [63:0] res;
    logic [63:0] trial;
    res = '0;
    for (int bitpos = 16; bitpos >= 0; bitpos--) begin
      trial = res | (64'd1 << bitpos);
      if (trial * trial <= arg) begin
        res = trial;
      end
    end
    return res;
  endfunction

  // One clamped bump term 1 - (c*(s-x))^2 - y in Q.30.
  function automatic logic [63:0] bump_q30(input logic [63:0] s30, input int b);
    logic [63:0]        cc;
    logic [63:0]        xx;
    logic [63:0]        yy;
    logic [63:0]        dist_abs;
    logic [63:0]        u;
    logic signed [63:0] val;
    cc       = dec_to_q30(DEC_C[b]);
    xx       = dec_to_q30(DEC_X[b]);
    yy       = dec_to_q30(DEC_Y[b]);
    dist_abs = (s30 >= xx) ? s30 - xx : xx - s30;
    u        = (cc * dist_abs) >> 30;
    if (u >= (64'd1 << 31)) begin
      return '0;
    end
    val = $signed(UNIT_Q30) - $signed((u * u) >> 30) - $signed(yy);
    if (val < 0) begin
      val = 0;
    end
    if (val > $signed(UNIT_Q30)) begin
      val = $signed(UNIT_Q30);
    end
    return val;
  endfunction

  function automatic colour_t predict_colour(input logic [16:0] intensity, input logic mode);
    logic [63:0] t;
    logic [63:0] root;
    logic [63:0] sum;
    logic [63:0] phase;
    logic [63:0] idx;
    logic [17:0] chan [3];
    colour_t     res;
    t = 64'(intensity);
    if (t > UNIT_F) begin
      t = UNIT_F;
    end
    root = root_q16(t << FRAC);
    for (int k = 0; k < 3; k++) begin
      if (mode == MODE_SPECTRAL) begin
        sum = bump_q30(root << (30 - FRAC), 2 * k) + bump_q30(root << (30 - FRAC), 2 * k + 1);
        chan[k] = 18'((sum + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
      end else begin
        // Phase (s - k/3) turns times the depth, scaled by three to stay exact.
        phase = 64'd3 * root * DEPTH + 64'(3 - k) * DEPTH * UNIT_F;
        idx = ((phase + 64'd3 * (UNIT_F >> 1)) / (64'd3 * UNIT_F)) % DEPTH;
        chan[k] = cos_lut[idx];
      end
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  task automatic compare_channel(input string label, input logic [17:0] want_v,
                                 input logic [17:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
      mismatches++;
    end
  endtask

  initial begin
    logic [63:0]        f;
    logic [63:0]        r;
    logic [63:0]        v;
    logic signed [63:0] c;
    mismatches = 0;
    for (int i = 0; i < DEPTH; i++) begin
      f = (64'(i) << 32) / DEPTH;
      r = {34'd0, f[29:0]};
      case (f[31:30])
        2'd0: c = cos_quadrant(r);
        2'd1: c = -cos_quadrant(UNIT_Q30 - r);
        2'd2: c = -cos_quadrant(r);
        default: c = cos_quadrant(UNIT_Q30 - r);
      endcase
      v = $signed(UNIT_Q30) + c;
      v = v >> 1;
      v = (v + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      cos_lut[i] = v[17:0];
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_copy = MODE_SPECTRAL;
      pending_colours.delete();
      colours_pending <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite && paddr[2] == REG_PALETTE_MODE) begin
          mode_copy = pwdata[0];
        end else if (!pwrite && paddr[2] == REG_PALETTE_MODE &&
                     prdata !== APB_DATA_W'(mode_copy)) begin
          $display("%0t: mode readback mismatch, expected %0d, actual %0d",
                   $time, mode_copy, prdata);
          mismatches++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_colours.push_back(predict_colour(s_axis_tdata[16:0], mode_copy));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[53:0];
        if (pending_colours.size() == 0) begin
          $display("%0t: unexpected colour beat, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = pending_colours.pop_front();
          compare_channel("red", want.red, got.red);
          compare_channel("green", want.green, got.green);
          compare_channel("blue", want.blue, got.blue);
        end
      end
      colours_pending <= pending_colours.size();
    end
  end

endmodule

// ===== tb/scalar_to_rgb_color_palette_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scalar to RGB colour palette testbench
// Drives intensity beats in random bursts against a stalling colour sink,
// switches the palette mode between phases and leaves the comparison of
// every colour beat to the checker.
// ----------------------------------------------------------------------------
module scalar_to_rgb_color_palette_test;
  import s2rgb_pkg::*;

  localparam int unsigned PIPE_LATENCY = 23;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_BEATS  = 250;
  localparam logic        REG_SPARE    = 1'b1;

  typedef enum logic [1:0] {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_style_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata  = '0;  // intensity [16:0], zero padding above
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [55:0]           m_axis_tdata;        // red [17:0], green [35:18], blue [53:36]
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned  colours_pending;
  int unsigned  mismatches;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left  = 0;
  int unsigned  ready_tick  = 0;
  logic [31:0]  ready_word  = '1;
  ready_style_e ready_style = READY_ALWAYS;

  scalar_to_rgb_color_palette dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  rgb_palette_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .colours_pending (colours_pending),
    .mismatches      (mismatches)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The sink periodically picks a new ready behaviour, sometimes never stalling.
  always @(posedge clk_i) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 64 == 0) begin
      ready_style <= ready_style_e'($urandom_range(0, 2));
      ready_word  <= $urandom;
    end
    case (ready_style)
      READY_ALWAYS:  m_axis_tready <= 1'b1;
      READY_PATTERN: m_axis_tready <= ready_word[ready_tick % 32];
      default:       m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_intensity(input logic [16:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) begin
          s_axis_tdata <= 24'($urandom);
          @(posedge clk_i);
        end
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, t};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Leaves the bus idle after each access so that accesses never overlap.
  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the stream and waits until every expected colour has left.
  task automatic drain_colours();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (colours_pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [16:0] edge_intensity(input int idx);
    case (idx)
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'd2;
      3:       return 17'd255;
      4:       return 17'd16384;
      5:       return 17'd31700;
      6:       return 17'd32768;
      7:       return 17'h0AAAA;
      8:       return 17'd65535;
      9:       return 17'd65536;
      10:      return 17'd65537;
      default: return 17'h1FFFF;
    endcase
  endfunction

  task automatic random_phase();
    int unsigned pick;
    for (int i = 0; i < PHASE_BEATS; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        send_intensity(17'($urandom_range(0, 65536)));
      end else if (pick < 17) begin
        send_intensity(17'($urandom_range(0, 255)));
      end else begin
        send_intensity(17'($urandom));
      end
    end
    drain_colours();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset selects the spectral palette.
    apb_access(1'b0, {REG_PALETTE_MODE, 2'b00}, '0);
    for (int i = 0; i < 12; i++) begin
      send_intensity(edge_intensity(i));
    end
    drain_colours();

    // Upper bits are ignored, and a write to an unmapped index must not land.
    apb_access(1'b1, {REG_PALETTE_MODE, 2'b00}, '1);
    apb_access(1'b1, {REG_SPARE, 2'b00}, '0);
    apb_access(1'b0, {REG_PALETTE_MODE, 2'b00}, '0);
    for (int i = 0; i < 12; i++) begin
      send_intensity(edge_intensity(i));
    end
    drain_colours();
    random_phase();

    apb_access(1'b1, {REG_PALETTE_MODE, 2'b00}, 32'hFFFF_FFFE);
    apb_access(1'b0, {REG_PALETTE_MODE, 2'b00}, '0);
    random_phase();

    apb_access(1'b1, {REG_PALETTE_MODE, 2'b00}, APB_DATA_W'(MODE_COSINE));
    random_phase();

    apb_access(1'b1, {REG_PALETTE_MODE, 2'b00}, APB_DATA_W'(MODE_SPECTRAL));
    apb_access(1'b0, {REG_PALETTE_MODE, 2'b00}, '0);
    random_phase();

    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
